/* src/assert_macros.svh */
// assertion macros shared by the rpn stack calculator rtl
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain invariant checked at every clock edge outside reset
`define RPN_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("rpn invariant violated");

// same-cycle implication
`define RPN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rpn implication violated");

// next-cycle implication
`define RPN_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rpn sequence violated");

`endif

/* src/rpn_pkg.sv */
// shared types and constants for the rpn stack calculator
// no dependencies
package rpn_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int AW          = $clog2(STACK_DEPTH);
  localparam int DW          = $clog2(STACK_DEPTH + 1);
  localparam int CNT_W       = 7;
  localparam int FACT_MAX    = 34;

  typedef enum logic [3:0] {
    REQ_PUSH    = 4'd0,
    REQ_ADD     = 4'd1,
    REQ_SUB     = 4'd2,
    REQ_MUL     = 4'd3,
    REQ_DIV     = 4'd4,
    REQ_MOD     = 4'd5,
    REQ_FACT    = 4'd6,
    REQ_POW     = 4'd7,
    REQ_PEEK    = 4'd8,
    REQ_CLEAR   = 4'd9,
    REQ_DUMP    = 4'd10,
    REQ_REVERSE = 4'd11
  } req_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FEW   = 3'd1,
    ST_DIV0  = 3'd2,
    ST_FULL  = 3'd3,
    ST_EMPTY = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL
  } alu_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_RDB,
    S_EXEC,
    S_DIV,
    S_DIVFIX,
    S_POW_M,
    S_POW_S,
    S_FACT,
    S_WRITE,
    S_DUMP_RD,
    S_DUMP_WAIT,
    S_REV_RDI,
    S_REV_RDJ,
    S_REV_WI,
    S_REV_WJ,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [3:0]         req_type;
    logic signed [31:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] out_value;
    logic [5:0]         out_depth;
    logic               last;
  } out_item_t;

endpackage

/* src/rpn_ram.sv */
// generic single write, single read ram with registered read data
// no dependencies
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/rpn_alu.sv */
// shared add, subtract and low-word multiply unit
// depends on rpn_pkg
module rpn_alu (
  input  rpn_pkg::alu_op_t op,
  input  logic [31:0]      x,
  input  logic [31:0]      y,
  output logic [31:0]      res
);
  import rpn_pkg::*;

  logic [63:0] prod;

  assign prod = x * y;

  always_comb begin
    unique case (op)
      ALU_ADD: res = x + y;
      ALU_SUB: res = x - y;
      ALU_MUL: res = prod[31:0];
      default: res = x + y;
    endcase
  end

endmodule

/* src/rpn_stack_calculator.sv */
// integer rpn stack calculator: sequencer, stack ram and shared alu
// depends on rpn_pkg, rpn_alu, rpn_ram and assert_macros.svh
//
// One request is taken at a time; in_stall is high from the transfer of a
// request until its last result has been loaded into the output register.
// The finished result may still wait there while the next request comes in.
// Per request: push, peek, clear and unused codes go from dispatch straight to
// the output; add, sub and mul read the second operand from the stack ram,
// pass once through the shared alu and write back; div and mod run a one-bit
// restoring step per cycle over 32 bits plus sign fixup; pow does two
// multiplies on the shared multiplier per exponent bit, stopping once the
// exponent runs out; factorial does one multiply per factor up to 34; reverse
// reads and then writes back each swapped pair through the stack ram; dump
// reads and emits one entry at a time, waiting on any output stall.
// Status codes follow the usual set: too few operands, divide by zero (also
// for a zero base with a negative exponent), stack full and stack empty.
// The stack ram needs no clearing pass: entries above the depth are never
// read.
module rpn_stack_calculator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rpn_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rpn_pkg::out_item_t out_data
);
  import rpn_pkg::*;

  `include "assert_macros.svh"

  // sequencer state
  state_t          state_r, state_nxt;
  req_t            req_r, req_nxt;
  status_t         status_r, status_nxt;
  logic [31:0]     pv_r, pv_nxt;
  logic [DW-1:0]   depth_r, depth_nxt;
  logic [31:0]     top_r, top_nxt;

  // operand and iteration registers
  logic [31:0]     a_r, a_nxt;
  logic [31:0]     b_r, b_nxt;
  logic [31:0]     acc_r, acc_nxt;
  logic [31:0]     e_r, e_nxt;
  logic [32:0]     rem_r, rem_nxt;
  logic [31:0]     quo_r, quo_nxt;
  logic            neg_a_r, neg_a_nxt;
  logic            neg_b_r, neg_b_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] lim_r, lim_nxt;
  logic [AW-1:0]   idx_i_r, idx_i_nxt;
  logic [AW-1:0]   idx_j_r, idx_j_nxt;
  logic [31:0]     tmp_r, tmp_nxt;

  // output register
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;

  // ram and alu hookup
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [31:0]     ram_wdata, ram_rdata;
  alu_op_t         alu_op;
  logic [31:0]     alu_x, alu_y, alu_res;

  // helpers
  logic            in_xfer;
  logic            out_free;
  logic [AW-1:0]   addr_top, addr_next;
  logic [32:0]     rem_sh;
  logic            rem_ge;
  logic            dump_last;
  logic            rev_more;
  logic            is_binary;
  logic [31:0]     top_shown;
  logic            wr_state;
  logic            depth_state;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign addr_top  = AW'(depth_r - DW'(1));
  assign addr_next = AW'(depth_r - DW'(2));
  assign rem_sh    = {rem_r[31:0], quo_r[31]};
  assign rem_ge    = (rem_sh >= {1'b0, b_r});
  assign dump_last = (DW'(cnt_r) == (depth_r - DW'(1)));
  assign rev_more  = (({1'b0, idx_j_r} - {1'b0, idx_i_r}) > (AW+1)'(2));
  assign top_shown = (depth_r == '0) ? 32'd0 : top_r;

  // states that may write the stack ram or change the depth
  assign wr_state    = (state_r == S_DISPATCH) || (state_r == S_WRITE) ||
                       (state_r == S_REV_WI) || (state_r == S_REV_WJ);
  assign depth_state = (state_r == S_DISPATCH) || (state_r == S_WRITE);

  always_comb begin
    unique case (req_r)
      REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV, REQ_MOD, REQ_POW: is_binary = 1'b1;
      default: is_binary = 1'b0;
    endcase
  end

  rpn_alu u_alu (
    .op  (alu_op),
    .x   (alu_x),
    .y   (alu_y),
    .res (alu_res)
  );

  rpn_ram #(
    .WIDTH (32),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (is_binary) begin
          state_nxt = (depth_r < DW'(2)) ? S_EMIT : S_RDB;
        end else begin
          unique case (req_r)
            REQ_FACT: begin
              if (depth_r == '0) state_nxt = S_EMIT;
              else if ($signed(top_r) < 32'sd2) state_nxt = S_WRITE;
              else state_nxt = S_FACT;
            end
            REQ_DUMP:    state_nxt = (depth_r == '0) ? S_EMIT : S_DUMP_RD;
            REQ_REVERSE: state_nxt = (depth_r > DW'(1)) ? S_REV_RDI : S_EMIT;
            default:     state_nxt = S_EMIT;
          endcase
        end
      end
      S_RDB: state_nxt = S_EXEC;
      S_EXEC: begin
        unique case (req_r)
          REQ_DIV, REQ_MOD: state_nxt = (b_r == '0) ? S_EMIT : S_DIV;
          REQ_POW: begin
            if (b_r[31]) state_nxt = (a_r == '0) ? S_EMIT : S_WRITE;
            else state_nxt = S_POW_M;
          end
          default: state_nxt = S_WRITE;
        endcase
      end
      S_DIV:       if (cnt_r == CNT_W'(31)) state_nxt = S_DIVFIX;
      S_DIVFIX:    state_nxt = S_WRITE;
      S_POW_M:     state_nxt = (e_r == '0) ? S_WRITE : S_POW_S;
      S_POW_S:     state_nxt = S_POW_M;
      S_FACT:      if (cnt_r == lim_r) state_nxt = S_WRITE;
      S_WRITE:     state_nxt = S_EMIT;
      S_DUMP_RD:   state_nxt = S_DUMP_WAIT;
      S_DUMP_WAIT: begin
        if (out_free) state_nxt = dump_last ? S_IDLE : S_DUMP_RD;
      end
      S_REV_RDI:   state_nxt = S_REV_RDJ;
      S_REV_RDJ:   state_nxt = S_REV_WI;
      S_REV_WI:    state_nxt = S_REV_WJ;
      S_REV_WJ:    state_nxt = rev_more ? S_REV_RDI : S_EMIT;
      S_EMIT:      if (out_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    req_nxt       = req_r;
    status_nxt    = status_r;
    pv_nxt        = pv_r;
    depth_nxt     = depth_r;
    top_nxt       = top_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    acc_nxt       = acc_r;
    e_nxt         = e_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    neg_a_nxt     = neg_a_r;
    neg_b_nxt     = neg_b_r;
    cnt_nxt       = cnt_r;
    lim_nxt       = lim_r;
    idx_i_nxt     = idx_i_r;
    idx_j_nxt     = idx_j_r;
    tmp_nxt       = tmp_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    alu_op        = ALU_ADD;
    alu_x         = '0;
    alu_y         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          req_nxt    = req_t'(in_data.req_type);
          pv_nxt     = in_data.push_value;
          status_nxt = ST_OK;
        end
      end
      S_DISPATCH: begin
        if (is_binary) begin
          if (depth_r < DW'(2)) begin
            status_nxt = ST_FEW;
          end else begin
            a_nxt     = top_r;
            ram_re    = 1'b1;
            ram_raddr = addr_next;
          end
        end else begin
          unique case (req_r)
            REQ_PUSH: begin
              if (depth_r == DW'(STACK_DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = AW'(depth_r);
                ram_wdata = pv_r;
                depth_nxt = depth_r + DW'(1);
                top_nxt   = pv_r;
              end
            end
            REQ_FACT: begin
              // factors run from 2 up to the argument, capped where the
              // product has wrapped to zero for good
              acc_nxt = 32'd1;
              cnt_nxt = CNT_W'(2);
              lim_nxt = ($signed(top_r) > 32'sd34) ? CNT_W'(FACT_MAX) : top_r[CNT_W-1:0];
              if (depth_r == '0) status_nxt = ST_FEW;
            end
            REQ_PEEK: begin
              if (depth_r == '0) status_nxt = ST_EMPTY;
            end
            REQ_CLEAR: depth_nxt = '0;
            REQ_DUMP: begin
              cnt_nxt = '0;
              if (depth_r == '0) status_nxt = ST_EMPTY;
            end
            REQ_REVERSE: begin
              idx_i_nxt = '0;
              idx_j_nxt = addr_top;
            end
            default: ;
          endcase
        end
      end
      S_RDB: b_nxt = ram_rdata;
      S_EXEC: begin
        unique case (req_r)
          REQ_ADD: begin
            alu_op = ALU_ADD; alu_x = a_r; alu_y = b_r; acc_nxt = alu_res;
          end
          REQ_SUB: begin
            alu_op = ALU_SUB; alu_x = a_r; alu_y = b_r; acc_nxt = alu_res;
          end
          REQ_MUL: begin
            alu_op = ALU_MUL; alu_x = a_r; alu_y = b_r; acc_nxt = alu_res;
          end
          REQ_DIV, REQ_MOD: begin
            // divide magnitudes, fix signs at the end
            if (b_r == '0) begin
              status_nxt = ST_DIV0;
            end else begin
              neg_a_nxt = a_r[31];
              neg_b_nxt = b_r[31];
              quo_nxt   = a_r[31] ? (32'd0 - a_r) : a_r;
              b_nxt     = b_r[31] ? (32'd0 - b_r) : b_r;
              rem_nxt   = '0;
              cnt_nxt   = '0;
            end
          end
          REQ_POW: begin
            if (b_r[31]) begin
              // negative exponent: only unit bases survive
              if (a_r == '0) status_nxt = ST_DIV0;
              else if (a_r == 32'd1) acc_nxt = 32'd1;
              else if (a_r == 32'hFFFF_FFFF) acc_nxt = b_r[0] ? 32'hFFFF_FFFF : 32'd1;
              else acc_nxt = 32'd0;
            end else begin
              acc_nxt = 32'd1;
              e_nxt   = b_r;
              b_nxt   = a_r;
            end
          end
          default: ;
        endcase
      end
      S_DIV: begin
        rem_nxt = rem_ge ? (rem_sh - {1'b0, b_r}) : rem_sh;
        quo_nxt = {quo_r[30:0], rem_ge};
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      S_DIVFIX: begin
        alu_op = ALU_SUB;
        if (req_r == REQ_DIV) begin
          alu_y   = quo_r;
          acc_nxt = (neg_a_r ^ neg_b_r) ? alu_res : quo_r;
        end else begin
          alu_y   = rem_r[31:0];
          acc_nxt = neg_a_r ? alu_res : rem_r[31:0];
        end
      end
      S_POW_M: begin
        alu_op = ALU_MUL; alu_x = acc_r; alu_y = b_r;
        if (e_r[0]) acc_nxt = alu_res;
      end
      S_POW_S: begin
        alu_op = ALU_MUL; alu_x = b_r; alu_y = b_r;
        b_nxt  = alu_res;
        e_nxt  = {1'b0, e_r[31:1]};
      end
      S_FACT: begin
        alu_op  = ALU_MUL; alu_x = acc_r; alu_y = 32'(cnt_r);
        acc_nxt = alu_res;
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      S_WRITE: begin
        ram_we    = 1'b1;
        ram_wdata = acc_r;
        top_nxt   = acc_r;
        if (req_r == REQ_FACT) begin
          ram_waddr = addr_top;
        end else begin
          ram_waddr = addr_next;
          depth_nxt = depth_r - DW'(1);
        end
      end
      S_DUMP_RD: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(depth_r - DW'(1) - DW'(cnt_r));
      end
      S_DUMP_WAIT: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.status    = ST_OK;
          out_data_nxt.out_value = ram_rdata;
          out_data_nxt.out_depth = 6'(depth_r);
          out_data_nxt.last      = dump_last;
          cnt_nxt                = cnt_r + CNT_W'(1);
        end
      end
      S_REV_RDI: begin
        ram_re    = 1'b1;
        ram_raddr = idx_i_r;
      end
      S_REV_RDJ: begin
        tmp_nxt   = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = idx_j_r;
      end
      S_REV_WI: begin
        ram_we    = 1'b1;
        ram_waddr = idx_i_r;
        ram_wdata = ram_rdata;
      end
      S_REV_WJ: begin
        ram_we    = 1'b1;
        ram_waddr = idx_j_r;
        ram_wdata = tmp_r;
        // the old bottom entry becomes the new top
        if (idx_i_r == '0) top_nxt = tmp_r;
        idx_i_nxt = idx_i_r + AW'(1);
        idx_j_nxt = idx_j_r - AW'(1);
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.status    = status_r;
          out_data_nxt.out_value = top_shown;
          out_data_nxt.out_depth = 6'(depth_r);
          out_data_nxt.last      = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    status_r   <= status_nxt;
    pv_r       <= pv_nxt;
    top_r      <= top_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    acc_r      <= acc_nxt;
    e_r        <= e_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    neg_a_r    <= neg_a_nxt;
    neg_b_r    <= neg_b_nxt;
    cnt_r      <= cnt_nxt;
    lim_r      <= lim_nxt;
    idx_i_r    <= idx_i_nxt;
    idx_j_r    <= idx_j_nxt;
    tmp_r      <= tmp_nxt;
    out_data_r <= out_data_nxt;
  end

  // checks
  `RPN_ASSERT(a_depth_bound, depth_r <= DW'(STACK_DEPTH))
  `RPN_ASSERT_NXT(a_accept_dispatch, in_xfer, state_r == S_DISPATCH)
  `RPN_ASSERT_IMP(a_ram_write_states, ram_we, wr_state)
  `RPN_ASSERT_IMP(a_div_count, state_r == S_DIV, cnt_r < CNT_W'(32))
  `RPN_ASSERT_IMP(a_depth_change, !$stable(depth_r), $past(depth_state))

endmodule
